// ----- rtl/core/nfc_pkg.sv -----
package nfc_pkg;

    localparam int unsigned NIB_W     = 4;
    localparam int unsigned NIB_COUNT = 16;
    localparam int unsigned CW_W      = 8;
    localparam int unsigned DIST_W    = 4;
    localparam int unsigned RATE_W    = 3;
    localparam int unsigned GRP_COUNT = NIB_COUNT / 4;

    localparam logic [NIB_W-1:0] NIB_MASK = 4'hf;

    // command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // code rates
    localparam logic [RATE_W-1:0] RATE_NONE = 3'd0;
    localparam logic [RATE_W-1:0] RATE_4_5  = 3'd1;
    localparam logic [RATE_W-1:0] RATE_4_6  = 3'd2;
    localparam logic [RATE_W-1:0] RATE_4_7  = 3'd3;
    localparam logic [RATE_W-1:0] RATE_4_8  = 3'd4;

    // one decode candidate: hamming distance and nibble
    typedef struct packed {
        logic [DIST_W-1:0] hd;
        logic [NIB_W-1:0]  idx;
    } nfc_cand_t;

    // out-of-range rates fall back to no parity
    function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] rate);
        logic [RATE_W-1:0] r;
        r = (rate <= RATE_4_8) ? rate : RATE_NONE;
        return r;
    endfunction

    // codeword bits that take part in decode
    function automatic logic [CW_W-1:0] rate_mask(input logic [RATE_W-1:0] rate);
        logic [CW_W-1:0] m;
        unique case (rate)
            RATE_4_5: m = 8'h1f;
            RATE_4_6: m = 8'h3f;
            RATE_4_7: m = 8'h7f;
            RATE_4_8: m = 8'hff;
            default:  m = 8'h0f;
        endcase
        return m;
    endfunction

    // nibble plus parity bits for the given rate
    function automatic logic [CW_W-1:0] fec_encode(input logic [NIB_W-1:0] nib,
                                                   input logic [RATE_W-1:0] rate);
        logic [CW_W-1:0] cw;
        logic            p0;
        logic            p1;
        logic            p2;
        logic            p3;
        p0 = nib[0] ^ nib[1] ^ nib[2];
        p1 = nib[1] ^ nib[2] ^ nib[3];
        p2 = nib[0] ^ nib[1] ^ nib[3];
        p3 = nib[0] ^ nib[2] ^ nib[3];
        cw = {4'b0000, nib};
        unique case (rate)
            RATE_4_5: cw[4]   = ^nib;
            RATE_4_6: cw[5:4] = {p1, p0};
            RATE_4_7: cw[6:4] = {p2, p1, p0};
            RATE_4_8: cw[7:4] = {p3, p2, p1, p0};
            default:  cw      = {4'b0000, nib};
        endcase
        return cw;
    endfunction

    // number of set bits in a codeword
    function automatic logic [DIST_W-1:0] popcount8(input logic [CW_W-1:0] v);
        logic [DIST_W-1:0] c;
        c = '0;
        for (int i = 0; i < CW_W; i++) begin
            c = c + DIST_W'(v[i]);
        end
        return c;
    endfunction

    // lower-index candidate wins a tie
    function automatic nfc_cand_t pick(input nfc_cand_t lo, input nfc_cand_t hi);
        nfc_cand_t w;
        w = (hi.hd < lo.hd) ? hi : lo;
        return w;
    endfunction

endpackage

// ----- rtl/core/nfc_min4.sv -----
// picks the closest of four candidates, lowest index on a tie
module nfc_min4 (
    input  nfc_pkg::nfc_cand_t [3:0] cands,
    output nfc_pkg::nfc_cand_t       best
);

    nfc_pkg::nfc_cand_t lo_win;
    nfc_pkg::nfc_cand_t hi_win;

    // two-level compare tree
    always_comb begin
        lo_win = nfc_pkg::pick(cands[0], cands[1]);
        hi_win = nfc_pkg::pick(cands[2], cands[3]);
        best   = nfc_pkg::pick(lo_win, hi_win);
    end

endmodule

// ----- rtl/core/nibble_fec_codec.sv -----
// Nibble FEC codec: encodes a 4-bit nibble with 0 to 4 parity bits (none, 4/5,
// 4/6, Hamming 7/4, Hamming 8/4) or decodes a received codeword by a
// nearest-codeword search over all 16 nibbles, lowest nibble winning ties.
// Rates 5 to 7 act as rate 0. The block is a four-stage pipeline: input
// register, 16 parallel distance counters, 16-to-4 minimum, 4-to-1 minimum
// into the output register. A request is taken every cycle while the pipeline
// has room; each result passes through these registers in order. Backpressure
// stops only the stages that hold data, so bubbles are filled while a result
// waits at the output.
module nibble_fec_codec (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] value
    input  logic [3:0] s_tuser,   // [0] command, [3:1] code_rate
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] result
);

    localparam int unsigned NIB_W  = nfc_pkg::NIB_W;
    localparam int unsigned CW_W   = nfc_pkg::CW_W;
    localparam int unsigned DIST_W = nfc_pkg::DIST_W;
    localparam int unsigned RATE_W = nfc_pkg::RATE_W;
    localparam int unsigned NCAND  = nfc_pkg::NIB_COUNT;
    localparam int unsigned NGRP   = nfc_pkg::GRP_COUNT;

    // stage valid flags
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: request captured, rate resolved, codeword masked
    logic              s1_cmd_reg;
    logic [RATE_W-1:0] s1_rate_reg;
    logic [CW_W-1:0]   s1_cw_reg;
    logic [CW_W-1:0]   s1_enc_reg;

    // stage 2: candidate distances
    logic [DIST_W-1:0] s2_dist_reg [NCAND];
    logic [DIST_W-1:0] s2_dist_next [NCAND];
    logic              s2_cmd_reg;
    logic [RATE_W-1:0] s2_rate_reg;
    logic [CW_W-1:0]   s2_enc_reg;

    // stage 3: group winners
    nfc_pkg::nfc_cand_t [NGRP-1:0] s3_grp_reg;
    nfc_pkg::nfc_cand_t [NGRP-1:0] s3_grp_next;
    logic              s3_cmd_reg;
    logic [CW_W-1:0]   s3_enc_reg;
    logic [RATE_W-1:0] s3_rate_reg;

    // stage 4: output register
    nfc_pkg::nfc_cand_t best;
    logic [CW_W-1:0]    m_data_reg;
    logic [CW_W-1:0]    m_data_next;

    logic              in_cmd;
    logic [RATE_W-1:0] in_rate;

    // per-stage ready: a stage loads when empty or its content moves on
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;
    assign m_tdata  = m_data_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1 logic
    assign in_cmd  = s_tuser[0];
    assign in_rate = nfc_pkg::eff_rate(s_tuser[3:1]);

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            s1_cmd_reg  <= in_cmd;
            s1_rate_reg <= in_rate;
            s1_cw_reg   <= s_tdata & nfc_pkg::rate_mask(in_rate);
            s1_enc_reg  <= nfc_pkg::fec_encode(s_tdata[NIB_W-1:0], in_rate);
        end
    end

    // stage 2: distance of every re-encoded candidate to the codeword
    always_comb begin
        for (int c = 0; c < NCAND; c++) begin
            s2_dist_next[c] = nfc_pkg::popcount8(
                nfc_pkg::fec_encode(NIB_W'(c), s1_rate_reg) ^ s1_cw_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            s2_dist_reg <= s2_dist_next;
            s2_cmd_reg  <= s1_cmd_reg;
            s2_rate_reg <= s1_rate_reg;
            s2_enc_reg  <= s1_enc_reg;
        end
    end

    // stage 3: minimum within each group of four
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        nfc_pkg::nfc_cand_t [3:0] grp_cands;
        for (genvar k = 0; k < 4; k++) begin : g_cand
            assign grp_cands[k].hd  = s2_dist_reg[4*g+k];
            assign grp_cands[k].idx = NIB_W'(4*g+k);
        end
        nfc_min4 u_min (
            .cands (grp_cands),
            .best  (s3_grp_next[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            s3_grp_reg  <= s3_grp_next;
            s3_cmd_reg  <= s2_cmd_reg;
            s3_enc_reg  <= s2_enc_reg;
            s3_rate_reg <= s2_rate_reg;
        end
    end

    // stage 4: overall winner, result select
    nfc_min4 u_min_final (
        .cands (s3_grp_reg),
        .best  (best)
    );

    always_comb begin
        unique case (s3_cmd_reg)
            nfc_pkg::CMD_DECODE: m_data_next = {{(CW_W-NIB_W){1'b0}}, best.idx};
            default:             m_data_next = s3_enc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    // an accepted request always lands in stage 1
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted request not captured in stage 1");

    // a result waiting at the output is never dropped
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_tready) |=> v4_reg)
        else $error("stalled result lost");

    // the winning distance never exceeds the compared codeword length
    a_dist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (best.hd <= DIST_W'(NIB_W) + DIST_W'(s3_rate_reg)))
        else $error("decode distance out of range");

    // a lone stage-1 item moves to stage 2 when stage 2 is free
    a_stage_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("stage 1 item not advanced");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int unsigned NIB_W     = nfc_pkg::NIB_W;
    localparam int unsigned CW_W      = nfc_pkg::CW_W;
    localparam int unsigned RATE_W    = nfc_pkg::RATE_W;
    localparam int unsigned NIB_COUNT = nfc_pkg::NIB_COUNT;

    // code rates above the defined range, treated as no parity
    localparam logic [RATE_W-1:0] RATE_SPARE_LO = 3'd5;
    localparam logic [RATE_W-1:0] RATE_SPARE_HI = 3'd7;

    localparam int unsigned ITEMS_PER_PHASE = 475;
    localparam int unsigned TAIL_CYCLES     = 16;

    // one codec request as it travels on the input channel
    typedef struct packed {
        logic              cmd;
        logic [RATE_W-1:0] rate;
        logic [CW_W-1:0]   value;
    } codec_req_t;

    // request together with the result it must produce
    typedef struct packed {
        codec_req_t      req;
        logic [CW_W-1:0] result;
    } codec_result_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] value
    logic [3:0] s_tuser  = '0;   // [0] command, [3:1] code_rate
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [7:0] result

    codec_req_t    req_queue[$];
    codec_result_t result_queue[$];
    int            error_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    nibble_fec_codec i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // number of codeword bits in play, out-of-range rates give the bare nibble
    function automatic int active_bits(input logic [RATE_W-1:0] rate);
        int n;
        n = NIB_W;
        if (rate <= nfc_pkg::RATE_4_8)
            n = NIB_W + int'(rate);
        return n;
    endfunction

    // nibble with its parity bits stacked above it
    function automatic logic [CW_W-1:0] parity_codeword(input logic [NIB_W-1:0] nib,
                                                        input logic [RATE_W-1:0] rate);
        logic [CW_W-1:0] cw;
        logic [3:0]      par;
        par[0] = nib[0] ^ nib[1] ^ nib[2];
        par[1] = nib[1] ^ nib[2] ^ nib[3];
        par[2] = nib[0] ^ nib[1] ^ nib[3];
        par[3] = nib[0] ^ nib[2] ^ nib[3];
        cw = {4'b0000, nib};
        case (rate)
            nfc_pkg::RATE_4_5: cw[4] = nib[0] ^ nib[1] ^ nib[2] ^ nib[3];
            nfc_pkg::RATE_4_6: cw[5:4] = par[1:0];
            nfc_pkg::RATE_4_7: cw[6:4] = par[2:0];
            nfc_pkg::RATE_4_8: cw[7:4] = par;
            default: ;
        endcase
        return cw;
    endfunction

    // closest nibble by hamming distance, first one found wins a tie
    function automatic logic [NIB_W-1:0] nearest_nibble(input logic [CW_W-1:0] cw,
                                                        input logic [RATE_W-1:0] rate);
        logic [CW_W-1:0]  span_mask;
        logic [NIB_W-1:0] best;
        int               min_hd;
        int               cand_hd;
        span_mask = CW_W'((1 << active_bits(rate)) - 1);
        best      = '0;
        min_hd    = CW_W + 1;
        for (int c = 0; c < NIB_COUNT; c++) begin
            cand_hd = $countones((parity_codeword(NIB_W'(c), rate) ^ cw) & span_mask);
            if (cand_hd < min_hd) begin
                min_hd = cand_hd;
                best   = NIB_W'(c);
            end
        end
        return best;
    endfunction

    function automatic logic [CW_W-1:0] codec_predict(input codec_req_t req);
        logic [CW_W-1:0] res;
        if (req.cmd == nfc_pkg::CMD_ENCODE)
            res = parity_codeword(req.value[NIB_W-1:0], req.rate);
        else
            res = {4'b0000, nearest_nibble(req.value, req.rate)};
        return res;
    endfunction

    // encodes get random values; decodes mostly get valid codewords with up to two bit errors, some pure noise
    function automatic codec_req_t random_req();
        codec_req_t      r;
        logic [CW_W-1:0] span_mask;
        int              span;
        int              flips;
        r.cmd = ($urandom_range(1) != 0) ? nfc_pkg::CMD_DECODE : nfc_pkg::CMD_ENCODE;
        if ($urandom_range(9) == 0)
            r.rate = RATE_W'($urandom_range(RATE_SPARE_HI, RATE_SPARE_LO));
        else
            r.rate = RATE_W'($urandom_range(nfc_pkg::RATE_4_8, nfc_pkg::RATE_NONE));
        span      = active_bits(r.rate);
        span_mask = CW_W'((1 << span) - 1);
        if (r.cmd == nfc_pkg::CMD_ENCODE || $urandom_range(99) < 15) begin
            r.value = CW_W'($urandom);
        end else begin
            r.value = parity_codeword(NIB_W'($urandom), r.rate);
            flips   = $urandom_range(2);
            repeat (flips) r.value[$urandom_range(span - 1)] ^= 1'b1;
            if ($urandom_range(1) != 0)
                r.value = r.value | (CW_W'($urandom) & ~span_mask);
        end
        return r;
    endfunction

    task automatic add_req(input logic cmd, input logic [RATE_W-1:0] rate,
                           input logic [CW_W-1:0] value);
        codec_req_t r;
        r.cmd     = cmd;
        r.rate    = rate;
        r.value   = value;
        req_queue = {req_queue, r};
    endtask

    // hold off until every request is sent and every result is back
    task automatic wait_idle();
        do @(negedge aclk);
        while (req_queue.size() != 0 || s_tvalid || result_queue.size() != 0);
    endtask

    // request driver
    always @(posedge aclk) begin : req_driver
        codec_req_t nxt;
        codec_result_t rec;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // record the expected result of an accepted request
            if (s_tvalid && s_tready) begin
                rec.req      = {s_tuser[0], s_tuser[3:1], s_tdata};
                rec.result   = codec_predict(rec.req);
                result_queue = {result_queue, rec};
            end
            if (!s_tvalid || s_tready) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = req_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tuser  <= {nxt.rate, nxt.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin : result_monitor
        codec_result_t exp_item;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual 0x%02h",
                             $realtime, m_tdata);
                    error_count++;
                end else begin
                    exp_item = result_queue.pop_front();
                    if (m_tdata !== exp_item.result) begin
                        $display("%0t: cmd %0d rate %0d value 0x%02h: expected 0x%02h, actual 0x%02h",
                                 $realtime, exp_item.req.cmd, exp_item.req.rate,
                                 exp_item.req.value, exp_item.result, m_tdata);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes at every rate
        for (int r = nfc_pkg::RATE_NONE; r <= nfc_pkg::RATE_4_8; r++) begin
            add_req(nfc_pkg::CMD_ENCODE, RATE_W'(r), 8'h00);
            add_req(nfc_pkg::CMD_ENCODE, RATE_W'(r), 8'h0f);
        end
        // upper nibble ignored on encode, spare rates
        add_req(nfc_pkg::CMD_ENCODE, nfc_pkg::RATE_4_8, 8'hf0);
        add_req(nfc_pkg::CMD_ENCODE, RATE_SPARE_HI, 8'ha5);
        add_req(nfc_pkg::CMD_DECODE, RATE_SPARE_LO, 8'ha7);
        add_req(nfc_pkg::CMD_DECODE, RATE_SPARE_HI, 8'h3c);
        // clean and out-of-span decodes
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_NONE, 8'h00);
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_NONE, 8'hff);
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_4_8, 8'hff);
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_4_7, 8'h80);
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_4_6, 8'h3f);
        // single parity bit cannot locate an error, ties go to the lowest nibble
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_4_5, 8'h10);
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_4_5, 8'h01);
        // one and two bit errors on hamming codes
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_4_7,
                parity_codeword(4'h9, nfc_pkg::RATE_4_7) ^ 8'h04);
        add_req(nfc_pkg::CMD_DECODE, nfc_pkg::RATE_4_8,
                parity_codeword(4'h6, nfc_pkg::RATE_4_8) ^ 8'h81);
        wait_idle();

        // random phases with different idle and stall mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            repeat (ITEMS_PER_PHASE) req_queue = {req_queue, random_req()};
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- nibble_fec_codec.f -----
rtl/core/nfc_pkg.sv
rtl/core/nfc_min4.sv
rtl/core/nibble_fec_codec.sv
dv/tb.sv
